FILE: rtl/core/pfc_pkg.sv
// ============================================================================
// pfc_pkg: shared types, codes and helpers for the Playfair digraph cipher
// Letter encoding, item modes, status codes, square geometry and the
// small helper functions used by the sequencer.
// ============================================================================
package pfc_pkg;

    // Square geometry
    localparam int unsigned Side    = 5;
    localparam int unsigned Cells   = Side * Side;
    localparam int unsigned Letters = 26;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;
    typedef logic [4:0] cell_idx_t;
    typedef logic [2:0] mode_t;
    typedef logic [1:0] status_t;

    // Letter codes
    localparam letter_t LETTER_I    = letter_t'(8);
    localparam letter_t LETTER_J    = letter_t'(9);
    localparam letter_t LAST_LETTER = letter_t'(Letters - 1);

    // Item modes
    localparam mode_t MODE_CLEAR   = 3'd0;
    localparam mode_t MODE_KEY     = 3'd1;
    localparam mode_t MODE_FINISH  = 3'd2;
    localparam mode_t MODE_ENCRYPT = 3'd3;
    localparam mode_t MODE_DECRYPT = 3'd4;

    // Status codes
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_NOT_READY = 2'd1;
    localparam status_t ST_FROZEN    = 2'd2;

    localparam coord_t LAST_COORD = coord_t'(Side - 1);
    localparam cell_idx_t FULL_COUNT = cell_idx_t'(Cells);

    // Position of a letter in the square
    typedef struct packed {
        coord_t row;
        coord_t col;
    } pfc_pos_t;

    // Sequencer requests to the table store
    typedef struct packed {
        logic      clear;
        logic      place;
        letter_t   place_letter;
        letter_t   pos_addr;
        cell_idx_t cell_addr;
    } pfc_store_req_t;

    // Fold j into i and clamp anything past z
    function automatic letter_t fold_letter(input letter_t l);
        letter_t r;
        r = (l > LAST_LETTER) ? LAST_LETTER : l;
        if (r == LETTER_J)
        begin
            r = LETTER_I;
        end
        return r;
    endfunction

    // Step a coordinate by one with wrap, forward or backward
    function automatic coord_t wrap_step(input coord_t x, input logic backward);
        coord_t r;
        if (backward)
        begin
            r = (x == '0) ? LAST_COORD : coord_t'(x - 3'd1);
        end
        else
        begin
            r = (x == LAST_COORD) ? '0 : coord_t'(x + 3'd1);
        end
        return r;
    endfunction

    // Row-major cell index: row * 5 + col
    function automatic cell_idx_t cell_index(input coord_t row, input coord_t col);
        return cell_idx_t'({row, 2'b00}) + cell_idx_t'(row) + cell_idx_t'(col);
    endfunction

endpackage

FILE: rtl/core/pfc_if.sv
// ============================================================================
// pfc_if: handshake channels of the Playfair digraph cipher
// Request channel carries one item per beat, response channel one result.
// ============================================================================
interface pfc_req_if;
    logic                valid;
    logic                ready;
    logic [2:0]          mode;
    logic [4:0]          first_letter;
    logic [4:0]          second_letter;

    modport source (output valid, output mode, output first_letter,
                    output second_letter, input ready);
    modport sink   (input valid, input mode, input first_letter,
                    input second_letter, output ready);
endinterface

interface pfc_rsp_if;
    logic                valid;
    logic                ready;
    logic [4:0]          first_out;
    logic [4:0]          second_out;
    logic [1:0]          status;

    modport source (output valid, output first_out, output second_out,
                    output status, input ready);
    modport sink   (input valid, input first_out, input second_out,
                    input status, output ready);
endinterface

FILE: rtl/core/playfair_digraph_cipher.sv
// ============================================================================
// playfair_digraph_cipher: Playfair cipher over a 5x5 key square
// Sequencer, shared coordinate step unit and result register on top of
// the table store.
// ============================================================================
// Takes one item at a time and returns one result per item. A finish item
// on an unfinished square walks all 26 letter codes one per cycle (j is
// still walked but places nothing), placing every letter not yet in the
// square through the single write port of the tables, and a cipher pair
// makes two position reads and two square reads in turn through one read
// port each, with one coordinate step unit shared by both letters. The next
// item is accepted as soon as a result is loaded into the output register,
// even if that result has not yet been taken.
module playfair_digraph_cipher (
    input  logic      clk,
    input  logic      rst_n,
    pfc_req_if.sink   req,
    pfc_rsp_if.source rsp
);
    import pfc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KEY   = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_POS_A = 4'd3;
    localparam logic [3:0] S_POS_B = 4'd4;
    localparam logic [3:0] S_CALC  = 4'd5;
    localparam logic [3:0] S_CELL1 = 4'd6;
    localparam logic [3:0] S_CELL2 = 4'd7;
    localparam logic [3:0] S_CAPT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;
    mode_t      mode_reg, mode_next;
    letter_t    a_reg, a_next;
    letter_t    b_reg, b_next;
    letter_t    walk_reg, walk_next;
    logic       sq_ready_reg, sq_ready_next;
    pfc_pos_t   pos_a_reg, pos_a_next;
    pfc_pos_t   pos_b_reg, pos_b_next;
    letter_t    o1_reg, o1_next;
    letter_t    o2_reg, o2_next;
    status_t    st_reg, st_next;

    logic       out_valid_reg, out_valid_next;
    letter_t    out_first_reg, out_first_next;
    letter_t    out_second_reg, out_second_next;
    status_t    out_status_reg, out_status_next;

    pfc_store_req_t store_req;
    pfc_pos_t       pos_rdata;
    letter_t        cell_rdata;

    logic     accept;
    logic     same_row, same_col;
    pfc_pos_t own_pos;
    coord_t   other_col;
    coord_t   step_in, step_out;
    coord_t   tgt_row, tgt_col;

    pfc_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (store_req),
        .pos_rdata  (pos_rdata),
        .cell_rdata (cell_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Shared coordinate step unit: serves the first letter, then the second
    assign same_row  = (pos_a_reg.row == pos_b_reg.row);
    assign same_col  = (pos_a_reg.col == pos_b_reg.col);
    assign own_pos   = (state_reg == S_CELL1) ? pos_a_reg : pos_b_reg;
    assign other_col = (state_reg == S_CELL1) ? pos_b_reg.col : pos_a_reg.col;
    assign step_in   = same_row ? own_pos.col : own_pos.row;
    assign step_out  = wrap_step(step_in, mode_reg == MODE_DECRYPT);

    always_comb
    begin
        if (same_row)
        begin
            tgt_row = own_pos.row;
            tgt_col = step_out;
        end
        else if (same_col)
        begin
            tgt_row = step_out;
            tgt_col = own_pos.col;
        end
        else
        begin
            tgt_row = own_pos.row;
            tgt_col = other_col;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        walk_next     = walk_reg;
        sq_ready_next = sq_ready_reg;
        pos_a_next    = pos_a_reg;
        pos_b_next    = pos_b_reg;
        o1_next       = o1_reg;
        o2_next       = o2_reg;
        st_next       = st_reg;

        store_req.clear        = 1'b0;
        store_req.place        = 1'b0;
        store_req.place_letter = a_reg;
        store_req.pos_addr     = a_reg;
        store_req.cell_addr    = cell_index(tgt_row, tgt_col);

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    a_next    = fold_letter(req.first_letter);
                    b_next    = fold_letter(req.second_letter);
                    o1_next   = '0;
                    o2_next   = '0;
                    st_next   = ST_DONE;
                    state_next = S_DONE;
                    case (req.mode)
                        MODE_CLEAR:
                        begin
                            store_req.clear = 1'b1;
                            sq_ready_next   = 1'b0;
                        end
                        MODE_KEY, MODE_FINISH:
                        begin
                            if (sq_ready_reg)
                            begin
                                st_next = ST_FROZEN;
                            end
                            else if (req.mode == MODE_KEY)
                            begin
                                state_next = S_KEY;
                            end
                            else
                            begin
                                walk_next  = '0;
                                state_next = S_FILL;
                            end
                        end
                        MODE_ENCRYPT, MODE_DECRYPT:
                        begin
                            if (!sq_ready_reg)
                            begin
                                st_next = ST_NOT_READY;
                            end
                            else
                            begin
                                state_next = S_POS_A;
                            end
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_KEY:
            begin
                store_req.place = 1'b1;
                state_next      = S_DONE;
            end
            S_FILL:
            begin
                // Walk the alphabet; the store skips letters already placed
                store_req.place        = (walk_reg != LETTER_J);
                store_req.place_letter = walk_reg;
                if (walk_reg == LAST_LETTER)
                begin
                    sq_ready_next = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            S_POS_A:
            begin
                store_req.pos_addr = a_reg;
                state_next         = S_POS_B;
            end
            S_POS_B:
            begin
                store_req.pos_addr = b_reg;
                pos_a_next         = pos_rdata;
                state_next         = S_CALC;
            end
            S_CALC:
            begin
                pos_b_next = pos_rdata;
                state_next = S_CELL1;
            end
            S_CELL1:
            begin
                state_next = S_CELL2;
            end
            S_CELL2:
            begin
                o1_next    = cell_rdata;
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                o2_next    = cell_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = o1_reg;
                    out_second_next = o2_reg;
                    out_status_next = st_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sq_ready_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sq_ready_reg  <= sq_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        walk_reg       <= walk_next;
        pos_a_reg      <= pos_a_next;
        pos_b_reg      <= pos_b_next;
        o1_reg         <= o1_next;
        o2_reg         <= o2_next;
        st_reg         <= st_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.first_out  = out_first_reg;
    assign rsp.second_out = out_second_reg;
    assign rsp.status     = out_status_reg;

endmodule

FILE: rtl/core/pfc_store.sv
// ============================================================================
// pfc_store: key square and letter position tables
// Holds the square memory, the letter position memory, the present bits
// and the fill counters. Places one letter per request; reads are registered.
// ============================================================================
module pfc_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pfc_pkg::pfc_store_req_t req,
    output pfc_pkg::pfc_pos_t       pos_rdata,
    output pfc_pkg::letter_t        cell_rdata
);
    import pfc_pkg::*;

    letter_t   key_mem [0:Cells-1];
    pfc_pos_t  pos_mem [0:Letters-1];

    logic [Letters-1:0] present_reg, present_next;
    cell_idx_t          fill_count_reg, fill_count_next;
    coord_t             fill_row_reg, fill_row_next;
    coord_t             fill_col_reg, fill_col_next;
    pfc_pos_t           pos_rdata_reg;
    letter_t            cell_rdata_reg;
    logic               do_place;

    // Place only a new letter into a square that still has room
    assign do_place = req.place && !present_reg[req.place_letter]
                      && (fill_count_reg != FULL_COUNT);

    // Fill counters and present bits
    always_comb
    begin
        present_next    = present_reg;
        fill_count_next = fill_count_reg;
        fill_row_next   = fill_row_reg;
        fill_col_next   = fill_col_reg;
        if (req.clear)
        begin
            present_next    = '0;
            fill_count_next = '0;
            fill_row_next   = '0;
            fill_col_next   = '0;
        end
        else if (do_place)
        begin
            present_next[req.place_letter] = 1'b1;
            fill_count_next = fill_count_reg + 5'd1;
            if (fill_col_reg == LAST_COORD)
            begin
                fill_col_next = '0;
                fill_row_next = fill_row_reg + 3'd1;
            end
            else
            begin
                fill_col_next = fill_col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            fill_count_reg <= '0;
            fill_row_reg   <= '0;
            fill_col_reg   <= '0;
        end
        else
        begin
            present_reg    <= present_next;
            fill_count_reg <= fill_count_next;
            fill_row_reg   <= fill_row_next;
            fill_col_reg   <= fill_col_next;
        end
    end

    // Table writes and registered reads
    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            key_mem[fill_count_reg]  <= req.place_letter;
            pos_mem[req.place_letter] <= '{row: fill_row_reg, col: fill_col_reg};
        end
        pos_rdata_reg  <= pos_mem[req.pos_addr];
        cell_rdata_reg <= key_mem[req.cell_addr];
    end

    assign pos_rdata  = pos_rdata_reg;
    assign cell_rdata = cell_rdata_reg;

endmodule
